>>> sv/fla_pkg.sv
// Shared constants, codes and transaction types of the free-list allocator.
package fla_pkg;

    localparam int REGION_BYTES = 65536;
    localparam int HEADER_BYTES = 16;
    localparam int PAGE_BYTES   = 4096;

    localparam int SLOTS      = REGION_BYTES / 8;
    localparam int IDX_W      = $clog2(SLOTS);
    localparam int OFF_W      = $clog2(REGION_BYTES);
    localparam int PTR_W      = OFF_W + 1;
    localparam int SIZE_W     = OFF_W + 1;
    localparam int STEP_W     = IDX_W + 1;
    localparam int ENTRY_W    = SIZE_W + PTR_W;
    localparam int REQ_W      = 17;
    localparam int NEED_W     = REQ_W + 1;
    localparam int PAGES_W    = 5;
    localparam int MAX_PAGES  = REGION_BYTES / PAGE_BYTES;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

    // Null link: top bit set, never a valid region offset
    localparam logic [PTR_W-1:0] NIL = {1'b1, {OFF_W{1'b0}}};

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2,
        FIT_NEXT  = 2'd3
    } fit_t;

    typedef enum logic [1:0] {
        STATUS_OK          = 2'd0,
        STATUS_ALLOC_FAIL  = 2'd1,
        STATUS_FREE_REJECT = 2'd2
    } status_t;

    typedef enum logic {
        CFG_REGION_PAGES = 1'b0,
        CFG_FIT_POLICY   = 1'b1
    } cfg_sel_t;

    typedef enum logic [4:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_PICKED,
        ST_SPLIT,
        ST_UNLINK_START,
        ST_UNLINK_RD,
        ST_UNLINK_EV,
        ST_ALLOC_DONE,
        ST_FREE_HDR_RD,
        ST_FREE_HDR_EV,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_LINK,
        ST_LINK_PREV,
        ST_MERGE_RD,
        ST_MERGE_EV,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        cmd_t              command;
        logic [REQ_W-1:0]  request_bytes;
        logic [OFF_W-1:0]  block_offset;
    } req_t;

    typedef struct packed {
        status_t           status;
        logic [OFF_W-1:0]  payload_offset;
    } rsp_t;

endpackage

>>> sv/free_list_allocator.sv
// Free-list allocator: header store, list-walking sequencer and response register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------
//  req     | in        | req_valid / req_ready | command, request_bytes, block_offset
//  rsp     | out       | rsp_valid / rsp_ready | status, payload_offset
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Every free-list node visited takes a read-issue state and then an evaluate state,
// set by the single read port of the header store, whose read data is registered.
// Allocate scans the list, then walks it again from the head up to the pick to
// unlink it; next fit may scan the list twice. Free walks the nodes below the
// block. After reset the INIT state writes the header of the whole-region block;
// the store has no clearing pass. A waiting response sits in its own register,
// so the next transaction is taken while it is pending.
module free_list_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  fla_pkg::req_t                req,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output fla_pkg::rsp_t                rsp,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  fla_pkg::cfg_sel_t            cfg_index,
    input  logic [fla_pkg::PAGES_W-1:0]  cfg_data
);

    localparam int OW = fla_pkg::OFF_W;
    localparam int PW = fla_pkg::PTR_W;
    localparam int SW = fla_pkg::SIZE_W;
    localparam int NW = fla_pkg::NEED_W;

    // Header store: {size, next} per 8-byte slot
    logic [fla_pkg::ENTRY_W-1:0] mem [fla_pkg::SLOTS];
    logic [fla_pkg::ENTRY_W-1:0] rd_data_reg;
    logic                        rd_en;
    logic [fla_pkg::IDX_W-1:0]   rd_addr;
    logic                        wr_en;
    logic [fla_pkg::IDX_W-1:0]   wr_addr;
    logic [fla_pkg::ENTRY_W-1:0] wr_data;

    fla_pkg::state_t  state_reg, state_next;
    fla_pkg::fit_t    policy_reg, policy_next;
    fla_pkg::status_t stat_reg, stat_next;
    logic [SW-1:0]    region_reg, region_next;
    logic [PW-1:0]    head_reg, head_next;
    logic [PW-1:0]    rov_reg, rov_next;
    logic [PW-1:0]    cur_reg, cur_next;
    logic [PW-1:0]    prev_reg, prev_next;
    logic [SW-1:0]    prev_size_reg, prev_size_next;
    logic [PW-1:0]    blk_reg, blk_next;
    logic [SW-1:0]    blk_size_reg, blk_size_next;
    logic [PW-1:0]    blk_link_reg, blk_link_next;
    logic [NW-1:0]    need_reg, need_next;
    logic [fla_pkg::STEP_W-1:0] steps_reg, steps_next;
    logic             pass2_reg, pass2_next;
    logic [OW-1:0]    res_off_reg, res_off_next;

    logic          rsp_valid_reg;
    fla_pkg::rsp_t rsp_reg;
    logic          rsp_load;

    function automatic logic [fla_pkg::IDX_W-1:0] slot(input logic [PW-1:0] p);
        slot = p[OW-1:3];
    endfunction

    // Handshakes
    logic req_fire, cfg_fire;
    assign cfg_ready = (state_reg == fla_pkg::ST_IDLE);
    assign req_ready = (state_reg == fla_pkg::ST_IDLE) && !cfg_valid;
    assign req_fire  = req_valid && req_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // Decoded read data
    logic [SW-1:0] rd_size;
    logic [PW-1:0] rd_link;
    assign rd_size = rd_data_reg[fla_pkg::ENTRY_W-1 -: SW];
    assign rd_link = rd_data_reg[PW-1:0];

    // Configuration: region re-forming size
    logic [fla_pkg::PAGES_W-1:0] pages_eff;
    logic [SW-1:0]               cfg_bytes;
    assign pages_eff = (cfg_data == '0) ? fla_pkg::PAGES_W'(1) : cfg_data;
    assign cfg_bytes = (pages_eff > fla_pkg::PAGES_W'(fla_pkg::MAX_PAGES))
                     ? SW'(fla_pkg::REGION_BYTES)
                     : (SW'(pages_eff) << fla_pkg::PAGE_SHIFT);

    // Incoming transaction checks
    logic [NW-1:0] req_need;
    logic          alloc_bad, free_bad;
    assign req_need  = ({1'b0, req.request_bytes} + NW'(7)) & ~NW'(7);
    assign alloc_bad = (req_need == '0) || head_reg[PW-1];
    assign free_bad  = (req.block_offset < OW'(fla_pkg::HEADER_BYTES))
                    || (req.block_offset[2:0] != 3'd0)
                    || ({1'b0, req.block_offset} > region_reg);

    // Scan and walk conditions
    logic is_ext, scan_end, fits, better, split, unlink_end, walk_go;
    logic hdr_too_big, merge_prev, merge_next;
    logic [NW-1:0] need_hdr;
    logic [OW-1:0] rest_off;
    logic [PW-1:0] rest_ptr;
    logic [SW-1:0] rest_size, prev_merged, blk_merged;

    assign is_ext   = (policy_reg == fla_pkg::FIT_BEST) || (policy_reg == fla_pkg::FIT_WORST);
    assign scan_end = cur_reg[PW-1] || (steps_reg == fla_pkg::STEP_W'(fla_pkg::SLOTS));
    assign fits     = {1'b0, rd_size} >= need_reg;
    assign better   = blk_reg[PW-1]
                   || ((policy_reg == fla_pkg::FIT_WORST) ? (rd_size > blk_size_reg)
                                                         : (rd_size < blk_size_reg));
    assign need_hdr  = need_reg + NW'(fla_pkg::HEADER_BYTES);
    assign split     = {1'b0, blk_size_reg} > need_hdr;
    assign rest_off  = OW'({2'b00, blk_reg[OW-1:0]} + need_hdr);
    assign rest_ptr  = {1'b0, rest_off};
    assign rest_size = SW'({1'b0, blk_size_reg} - need_hdr);
    assign unlink_end = scan_end;
    assign walk_go   = !scan_end && (cur_reg[OW-1:0] < blk_reg[OW-1:0]);
    assign hdr_too_big = rd_size > (region_reg - (SW'(blk_reg[OW-1:0])
                                                 + SW'(fla_pkg::HEADER_BYTES)));
    assign merge_prev = !prev_reg[PW-1]
                     && (({1'b0, prev_reg} + NW'(fla_pkg::HEADER_BYTES)
                          + {1'b0, prev_size_reg}) == {1'b0, blk_reg});
    assign merge_next = !cur_reg[PW-1]
                     && (({1'b0, blk_reg} + NW'(fla_pkg::HEADER_BYTES)
                          + {1'b0, blk_size_reg}) == {1'b0, cur_reg});
    assign prev_merged = SW'(prev_size_reg + SW'(fla_pkg::HEADER_BYTES) + blk_size_reg);
    assign blk_merged  = SW'(blk_size_reg + SW'(fla_pkg::HEADER_BYTES) + rd_size);

    assign rsp_load = (state_reg == fla_pkg::ST_RESPOND) && (!rsp_valid_reg || rsp_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fla_pkg::ST_INIT:
                state_next = fla_pkg::ST_IDLE;
            fla_pkg::ST_IDLE:
                if (req_fire)
                begin
                    if (req.command == fla_pkg::CMD_ALLOC)
                        state_next = alloc_bad ? fla_pkg::ST_RESPOND : fla_pkg::ST_SCAN_RD;
                    else
                        state_next = free_bad ? fla_pkg::ST_RESPOND : fla_pkg::ST_FREE_HDR_RD;
                end
            fla_pkg::ST_SCAN_RD:
                if (!scan_end)
                    state_next = fla_pkg::ST_SCAN_EV;
                else if (is_ext)
                    state_next = blk_reg[PW-1] ? fla_pkg::ST_RESPOND : fla_pkg::ST_PICKED;
                else if (policy_reg == fla_pkg::FIT_NEXT && !pass2_reg)
                    state_next = fla_pkg::ST_SCAN_RD;
                else
                    state_next = fla_pkg::ST_RESPOND;
            fla_pkg::ST_SCAN_EV:
                if (is_ext)
                    state_next = fla_pkg::ST_SCAN_RD;
                else if (fits)
                    state_next = fla_pkg::ST_PICKED;
                else if (pass2_reg && rd_link == rov_reg)
                    state_next = fla_pkg::ST_RESPOND;
                else
                    state_next = fla_pkg::ST_SCAN_RD;
            fla_pkg::ST_PICKED:
                state_next = split ? fla_pkg::ST_SPLIT : fla_pkg::ST_UNLINK_START;
            fla_pkg::ST_SPLIT:
                state_next = fla_pkg::ST_UNLINK_START;
            fla_pkg::ST_UNLINK_START:
                state_next = (head_reg == blk_reg) ? fla_pkg::ST_ALLOC_DONE
                                                   : fla_pkg::ST_UNLINK_RD;
            fla_pkg::ST_UNLINK_RD:
                state_next = unlink_end ? fla_pkg::ST_ALLOC_DONE : fla_pkg::ST_UNLINK_EV;
            fla_pkg::ST_UNLINK_EV:
                state_next = (rd_link == blk_reg) ? fla_pkg::ST_ALLOC_DONE
                                                  : fla_pkg::ST_UNLINK_RD;
            fla_pkg::ST_ALLOC_DONE:
                state_next = fla_pkg::ST_RESPOND;
            fla_pkg::ST_FREE_HDR_RD:
                state_next = fla_pkg::ST_FREE_HDR_EV;
            fla_pkg::ST_FREE_HDR_EV:
                state_next = hdr_too_big ? fla_pkg::ST_RESPOND : fla_pkg::ST_WALK_RD;
            fla_pkg::ST_WALK_RD:
                if (walk_go)
                    state_next = fla_pkg::ST_WALK_EV;
                else
                    state_next = (cur_reg == blk_reg) ? fla_pkg::ST_RESPOND : fla_pkg::ST_LINK;
            fla_pkg::ST_WALK_EV:
                state_next = fla_pkg::ST_WALK_RD;
            fla_pkg::ST_LINK:
                state_next = (merge_prev || prev_reg[PW-1]) ? fla_pkg::ST_MERGE_RD
                                                            : fla_pkg::ST_LINK_PREV;
            fla_pkg::ST_LINK_PREV:
                state_next = fla_pkg::ST_MERGE_RD;
            fla_pkg::ST_MERGE_RD:
                state_next = merge_next ? fla_pkg::ST_MERGE_EV : fla_pkg::ST_RESPOND;
            fla_pkg::ST_MERGE_EV:
                state_next = fla_pkg::ST_RESPOND;
            fla_pkg::ST_RESPOND:
                if (rsp_load)
                    state_next = fla_pkg::ST_IDLE;
            default:
                state_next = fla_pkg::ST_IDLE;
        endcase
    end

    // Datapath, store accesses and list registers
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = slot(cur_reg);
        wr_en          = 1'b0;
        wr_addr        = slot(blk_reg);
        wr_data        = {blk_size_reg, cur_reg};
        policy_next    = policy_reg;
        region_next    = region_reg;
        head_next      = head_reg;
        rov_next       = rov_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        prev_size_next = prev_size_reg;
        blk_next       = blk_reg;
        blk_size_next  = blk_size_reg;
        blk_link_next  = blk_link_reg;
        need_next      = need_reg;
        steps_next     = steps_reg;
        pass2_next     = pass2_reg;
        stat_next      = stat_reg;
        res_off_next   = res_off_reg;
        case (state_reg)
            fla_pkg::ST_INIT:
            begin
                // Lay down the whole-region block after reset
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = {SW'(region_reg - SW'(fla_pkg::HEADER_BYTES)), fla_pkg::NIL};
            end
            fla_pkg::ST_IDLE:
            begin
                if (cfg_fire)
                begin
                    // Any register write re-forms the region as one free block
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    head_next = '0;
                    rov_next  = fla_pkg::NIL;
                    if (cfg_index == fla_pkg::CFG_REGION_PAGES)
                    begin
                        region_next = cfg_bytes;
                        wr_data = {SW'(cfg_bytes - SW'(fla_pkg::HEADER_BYTES)), fla_pkg::NIL};
                    end
                    else
                    begin
                        policy_next = fla_pkg::fit_t'(cfg_data[1:0]);
                        wr_data = {SW'(region_reg - SW'(fla_pkg::HEADER_BYTES)), fla_pkg::NIL};
                    end
                end
                if (req_fire)
                begin
                    res_off_next = '0;
                    steps_next   = '0;
                    pass2_next   = 1'b0;
                    need_next    = req_need;
                    if (req.command == fla_pkg::CMD_ALLOC)
                    begin
                        stat_next = fla_pkg::STATUS_ALLOC_FAIL;
                        blk_next  = fla_pkg::NIL;
                        cur_next  = (policy_reg == fla_pkg::FIT_NEXT && !rov_reg[PW-1])
                                  ? rov_reg : head_reg;
                    end
                    else
                    begin
                        stat_next = fla_pkg::STATUS_FREE_REJECT;
                        blk_next  = {1'b0, OW'(req.block_offset
                                               - OW'(fla_pkg::HEADER_BYTES))};
                    end
                end
            end
            fla_pkg::ST_SCAN_RD:
            begin
                if (!scan_end)
                    rd_en = 1'b1;
                else if (!is_ext && policy_reg == fla_pkg::FIT_NEXT && !pass2_reg)
                begin
                    // Wrap around: second pass from the head up to the roving start
                    pass2_next = 1'b1;
                    cur_next   = head_reg;
                    steps_next = '0;
                end
            end
            fla_pkg::ST_SCAN_EV:
            begin
                if (fits && (!is_ext || better))
                begin
                    blk_next      = cur_reg;
                    blk_size_next = rd_size;
                    blk_link_next = rd_link;
                end
                cur_next   = rd_link;
                steps_next = steps_reg + 1'b1;
            end
            fla_pkg::ST_PICKED:
            begin
                if (split)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot(rest_ptr);
                    wr_data = {rest_size, blk_link_reg};
                end
            end
            fla_pkg::ST_SPLIT:
            begin
                wr_en         = 1'b1;
                wr_addr       = slot(blk_reg);
                wr_data       = {SW'(need_reg), rest_ptr};
                blk_link_next = rest_ptr;
            end
            fla_pkg::ST_UNLINK_START:
            begin
                if (head_reg == blk_reg)
                    head_next = blk_link_reg;
                cur_next   = head_reg;
                steps_next = '0;
            end
            fla_pkg::ST_UNLINK_RD:
            begin
                rd_en = !unlink_end;
            end
            fla_pkg::ST_UNLINK_EV:
            begin
                if (rd_link == blk_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = slot(cur_reg);
                    wr_data = {rd_size, blk_link_reg};
                end
                cur_next   = rd_link;
                steps_next = steps_reg + 1'b1;
            end
            fla_pkg::ST_ALLOC_DONE:
            begin
                if (policy_reg == fla_pkg::FIT_NEXT)
                    rov_next = blk_link_reg;
                stat_next    = fla_pkg::STATUS_OK;
                res_off_next = OW'(blk_reg[OW-1:0] + OW'(fla_pkg::HEADER_BYTES));
            end
            fla_pkg::ST_FREE_HDR_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = slot(blk_reg);
            end
            fla_pkg::ST_FREE_HDR_EV:
            begin
                blk_size_next = rd_size;
                cur_next      = head_reg;
                prev_next     = fla_pkg::NIL;
                steps_next    = '0;
            end
            fla_pkg::ST_WALK_RD:
            begin
                rd_en = walk_go;
            end
            fla_pkg::ST_WALK_EV:
            begin
                prev_next      = cur_reg;
                prev_size_next = rd_size;
                cur_next       = rd_link;
                steps_next     = steps_reg + 1'b1;
            end
            fla_pkg::ST_LINK:
            begin
                wr_en = 1'b1;
                if (merge_prev)
                begin
                    // Absorb into the lower neighbour
                    wr_addr       = slot(prev_reg);
                    wr_data       = {prev_merged, cur_reg};
                    blk_next      = prev_reg;
                    blk_size_next = prev_merged;
                end
                else
                begin
                    wr_addr = slot(blk_reg);
                    wr_data = {blk_size_reg, cur_reg};
                    if (prev_reg[PW-1])
                        head_next = blk_reg;
                end
            end
            fla_pkg::ST_LINK_PREV:
            begin
                wr_en   = 1'b1;
                wr_addr = slot(prev_reg);
                wr_data = {prev_size_reg, blk_reg};
            end
            fla_pkg::ST_MERGE_RD:
            begin
                rd_en = merge_next;
                if (!merge_next)
                    stat_next = fla_pkg::STATUS_OK;
            end
            fla_pkg::ST_MERGE_EV:
            begin
                // Absorb the upper neighbour
                if (policy_reg == fla_pkg::FIT_NEXT && cur_reg == rov_reg)
                    rov_next = blk_reg;
                wr_en     = 1'b1;
                wr_addr   = slot(blk_reg);
                wr_data   = {blk_merged, rd_link};
                stat_next = fla_pkg::STATUS_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fla_pkg::ST_INIT;
            policy_reg    <= fla_pkg::FIT_FIRST;
            region_reg    <= SW'(fla_pkg::REGION_BYTES);
            head_reg      <= '0;
            rov_reg       <= fla_pkg::NIL;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            policy_reg <= policy_next;
            region_reg <= region_next;
            head_reg   <= head_next;
            rov_reg    <= rov_next;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        prev_size_reg <= prev_size_next;
        blk_reg       <= blk_next;
        blk_size_reg  <= blk_size_next;
        blk_link_reg  <= blk_link_next;
        need_reg      <= need_next;
        steps_reg     <= steps_next;
        pass2_reg     <= pass2_next;
        stat_reg      <= stat_next;
        res_off_reg   <= res_off_next;
        if (rsp_load)
        begin
            rsp_reg.status         <= stat_reg;
            rsp_reg.payload_offset <= res_off_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/fla_checker.sv
// Port-level checks of the free-list allocator and their binding to the top level.
module fla_assertions (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input fla_pkg::rsp_t rsp,
    input logic          cfg_ready
);

    // A response waiting for its taker stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before its transaction completed");

    // Failed transactions carry no offset
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status != fla_pkg::STATUS_OK |-> rsp.payload_offset == '0)
        else $error("non-zero offset on a failed transaction");

    // Allocated payloads are 8-byte aligned
    a_align: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == fla_pkg::STATUS_OK |-> rsp.payload_offset[2:0] == 3'd0)
        else $error("misaligned payload offset");

    // Requests are only taken when configuration could be taken too
    a_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> cfg_ready)
        else $error("request taken outside idle");

    // Every accepted request takes the sequencer out of idle, so requests are never accepted back to back
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted on consecutive cycles");

endmodule

bind free_list_allocator fla_assertions u_fla_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_ready (cfg_ready)
);
